>>> rtl/core/macc_pkg.sv
// ----------------------------------------------------------------------------
// macc_pkg
// Shared constants, payload structs and item codes for the multichannel
// moving average and calibration core.
// ----------------------------------------------------------------------------
`default_nettype none

package macc_pkg;

  localparam int CHANNELS    = 32;
  localparam int WINDOW_LOG2 = 3;

  localparam int SAMPLE_W   = 12;
  localparam int CH_W       = 5;
  localparam int COEF_W     = 32;
  localparam int WIN_LEN    = 1 << WINDOW_LOG2;
  localparam int SUM_W      = SAMPLE_W + WINDOW_LOG2;
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RING_DEPTH = CHANNELS * WIN_LEN;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Q8.24 * integer mean + Q16.16 << 8, then drop 8 fraction bits
  localparam int FRAC_DROP = 8;
  localparam int PROD_W    = COEF_W + SAMPLE_W + 1;
  localparam int ACC_W     = PROD_W + 1;
  localparam int Q_W       = ACC_W - FRAC_DROP;

  localparam logic [CH_W:0] CH_LIMIT = (CH_W + 1)'(CHANNELS);

  localparam logic signed [COEF_W-1:0] VOLT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] VOLT_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_LOAD,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    logic                     mode;
    logic [CH_W-1:0]          channel;
    logic [SAMPLE_W-1:0]      sample;
    logic signed [COEF_W-1:0] gain;
    logic signed [COEF_W-1:0] offset;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0]          out_channel;
    logic [SAMPLE_W-1:0]      last_sample;
    logic [SAMPLE_W-1:0]      mean;
    logic signed [COEF_W-1:0] voltage;
    logic                     channel_error;
  } out_t;

  // classified item, front to back
  typedef struct packed {
    kind_t                    kind;
    logic [CH_W-1:0]          channel;
    logic [SAMPLE_W-1:0]      sample;
    logic signed [COEF_W-1:0] gain;
    logic signed [COEF_W-1:0] offset;
  } cmd_t;

  // channel state after the update, ready for calibration
  typedef struct packed {
    logic                     err;
    logic [CH_W-1:0]          channel;
    logic [SAMPLE_W-1:0]      last_sample;
    logic [SAMPLE_W-1:0]      mean;
    logic signed [COEF_W-1:0] gain;
    logic signed [COEF_W-1:0] offset;
  } calc_t;

endpackage

`default_nettype wire

>>> rtl/core/multichannel_adc_average_calibrate_core.sv
// ----------------------------------------------------------------------------
// multichannel_adc_average_calibrate_core
// Per-channel moving average of 12-bit converter samples with linear
// calibration to a saturated Q16.16 voltage; also loads gain and offset.
// ----------------------------------------------------------------------------
//
//   port group   dir   handshake            payload
//   in_*         in    in_valid/in_ready    in_t  (mode, channel, sample,
//                                                  gain, offset)
//   out_*        out   out_valid/out_ready  out_t (out_channel, last_sample,
//                                                  mean, voltage, channel_error)
//
// One item per cycle sustained while the output is not stalled; a result
// passes the queue, s2, s3, s4 and the output register. The rate rests on
// the sample ring (one read-first write port) and per-channel sums in flops.
// Reset clears the channel tables at once; a per-channel wrap flag makes
// ring slots not yet written read as zero, so there is no clearing pass.
// A two-entry queue separates the input from the back end; an output stall
// freezes the back end only.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_adc_average_calibrate_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire macc_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output macc_pkg::out_t      out_data
);

  logic             cmd_valid;
  logic             cmd_ready;
  macc_pkg::cmd_t   cmd;
  logic             calc_valid;
  macc_pkg::calc_t  calc;
  logic             adv;

  macc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  macc_track u_track (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .calc_valid (calc_valid),
    .calc       (calc)
  );

  macc_calib u_calib (
    .clk        (clk),
    .rst        (rst),
    .calc_valid (calc_valid),
    .calc       (calc),
    .adv        (adv),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/core/macc_ram.sv
// ----------------------------------------------------------------------------
// macc_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
`default_nettype none

module macc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/macc_front.sv
// ----------------------------------------------------------------------------
// macc_front
// Accepts input items, classifies them as sample, load or bad channel, and
// queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module macc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire macc_pkg::in_t in_data,
  output logic               cmd_valid,
  input  wire logic          cmd_ready,
  output macc_pkg::cmd_t     cmd
);

  macc_pkg::cmd_t                  entries [macc_pkg::QUEUE_DEPTH];
  macc_pkg::cmd_t                  cls;
  logic [macc_pkg::QUEUE_AW-1:0]   wr_ptr;
  logic [macc_pkg::QUEUE_AW-1:0]   rd_ptr;
  logic [macc_pkg::QUEUE_AW:0]     count;
  logic                            push;
  logic                            pop;

  always_comb begin
    cls.channel = in_data.channel;
    cls.sample  = in_data.sample;
    cls.gain    = in_data.gain;
    cls.offset  = in_data.offset;
    priority if ({1'b0, in_data.channel} >= macc_pkg::CH_LIMIT) begin
      cls.kind = macc_pkg::KIND_BAD;
    end else if (in_data.mode) begin
      cls.kind = macc_pkg::KIND_LOAD;
    end else begin
      cls.kind = macc_pkg::KIND_SAMPLE;
    end
  end

  assign in_ready  = (count != (macc_pkg::QUEUE_AW + 1)'(macc_pkg::QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == macc_pkg::QUEUE_AW'(macc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == macc_pkg::QUEUE_AW'(macc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/macc_track.sv
// ----------------------------------------------------------------------------
// macc_track
// Per-channel state: sample ring, write pointer, running sum, latest sample
// and calibration coefficients. Two stages: ring access, then sum update.
// ----------------------------------------------------------------------------
`default_nettype none

module macc_track (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire macc_pkg::cmd_t cmd,
  output logic                calc_valid,
  output macc_pkg::calc_t     calc
);

  // per-channel tables, one read address each
  logic [macc_pkg::WINDOW_LOG2-1:0] wptr      [macc_pkg::CHANNELS];
  logic                             wrapped   [macc_pkg::CHANNELS];
  logic [macc_pkg::SUM_W-1:0]       sum_tab   [macc_pkg::CHANNELS];
  logic [macc_pkg::SAMPLE_W-1:0]    latest    [macc_pkg::CHANNELS];
  logic signed [macc_pkg::COEF_W-1:0] gain_tab [macc_pkg::CHANNELS];
  logic signed [macc_pkg::COEF_W-1:0] off_tab  [macc_pkg::CHANNELS];

  logic                             fire;
  logic                             is_sample;
  logic                             is_load;
  logic [macc_pkg::CH_IDX_W-1:0]    idx;
  logic [macc_pkg::WINDOW_LOG2-1:0] ptr;
  logic [macc_pkg::RING_AW-1:0]     ring_addr;
  logic [macc_pkg::SAMPLE_W-1:0]    ring_rd;

  // second stage
  logic                             s2_valid;
  macc_pkg::cmd_t                   s2_cmd;
  logic                             s2_wrapped;
  logic [macc_pkg::SAMPLE_W-1:0]    s2_last;
  logic [macc_pkg::CH_IDX_W-1:0]    s2_idx;
  logic [macc_pkg::SAMPLE_W-1:0]    old_sample;
  logic [macc_pkg::SUM_W-1:0]       sum_new;

  assign cmd_ready = adv;
  assign fire      = adv && cmd_valid;
  assign is_sample = (cmd.kind == macc_pkg::KIND_SAMPLE);
  assign is_load   = (cmd.kind == macc_pkg::KIND_LOAD);
  assign idx       = cmd.channel[macc_pkg::CH_IDX_W-1:0];
  assign ptr       = wptr[idx];
  assign ring_addr = macc_pkg::RING_AW'({idx, ptr});

  // read-first: the old entry comes back while the new sample goes in
  macc_ram #(
    .WIDTH (macc_pkg::SAMPLE_W),
    .DEPTH (macc_pkg::RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (fire && is_sample),
    .wr_addr (ring_addr),
    .wr_data (cmd.sample),
    .rd_en   (fire),
    .rd_addr (ring_addr),
    .rd_data (ring_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < macc_pkg::CHANNELS; i++) begin
        wptr[i]     <= '0;
        wrapped[i]  <= 1'b0;
        latest[i]   <= '0;
        gain_tab[i] <= '0;
        off_tab[i]  <= '0;
      end
    end else if (fire) begin
      if (is_sample) begin
        wptr[idx]   <= ptr + 1'b1;
        latest[idx] <= cmd.sample;
        if (ptr == '1) begin
          wrapped[idx] <= 1'b1;
        end
      end else if (is_load) begin
        gain_tab[idx] <= cmd.gain;
        off_tab[idx]  <= cmd.offset;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cmd.kind    <= cmd.kind;
      s2_cmd.channel <= cmd.channel;
      s2_cmd.sample  <= cmd.sample;
      s2_cmd.gain    <= is_load ? cmd.gain : gain_tab[idx];
      s2_cmd.offset  <= is_load ? cmd.offset : off_tab[idx];
      s2_wrapped     <= wrapped[idx];
      s2_last        <= is_sample ? cmd.sample : latest[idx];
    end
  end

  // ring entries never written since reset read as zero
  assign s2_idx     = s2_cmd.channel[macc_pkg::CH_IDX_W-1:0];
  assign old_sample = s2_wrapped ? ring_rd : '0;

  always_comb begin
    if (s2_cmd.kind == macc_pkg::KIND_SAMPLE) begin
      sum_new = sum_tab[s2_idx] - macc_pkg::SUM_W'(old_sample)
              + macc_pkg::SUM_W'(s2_cmd.sample);
    end else begin
      sum_new = sum_tab[s2_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < macc_pkg::CHANNELS; i++) begin
        sum_tab[i] <= '0;
      end
    end else if (adv && s2_valid && (s2_cmd.kind == macc_pkg::KIND_SAMPLE)) begin
      sum_tab[s2_idx] <= sum_new;
    end
  end

  assign calc_valid = s2_valid;

  always_comb begin
    calc.channel = s2_cmd.channel;
    if (s2_cmd.kind == macc_pkg::KIND_BAD) begin
      calc.err         = 1'b1;
      calc.last_sample = '0;
      calc.mean        = '0;
      calc.gain        = '0;
      calc.offset      = '0;
    end else begin
      calc.err         = 1'b0;
      calc.last_sample = s2_last;
      calc.mean        = sum_new[macc_pkg::SUM_W-1:macc_pkg::WINDOW_LOG2];
      calc.gain        = s2_cmd.gain;
      calc.offset      = s2_cmd.offset;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/macc_calib.sv
// ----------------------------------------------------------------------------
// macc_calib
// Calibration pipeline: gain * mean, offset add with floor to Q16.16,
// saturation, and the output register. Drives the shared advance enable.
// ----------------------------------------------------------------------------
`default_nettype none

module macc_calib (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            calc_valid,
  input  wire macc_pkg::calc_t calc,
  output logic                 adv,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output macc_pkg::out_t       out_data
);

  logic                                s3_valid;
  macc_pkg::calc_t                     s3;
  logic signed [macc_pkg::PROD_W-1:0]  prod;

  logic                                s4_valid;
  macc_pkg::calc_t                     s4;
  logic signed [macc_pkg::PROD_W-1:0]  s4_prod;

  logic signed [macc_pkg::ACC_W-1:0]   acc;
  logic signed [macc_pkg::Q_W-1:0]     q;
  logic signed [macc_pkg::COEF_W-1:0]  volt;
  macc_pkg::out_t                      res;

  // whole back end moves together whenever the output register can take
  assign adv = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s3_valid  <= calc_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  assign prod = s3.gain * $signed({1'b0, s3.mean});

  always_ff @(posedge clk) begin
    if (adv) begin
      s3       <= calc;
      s4       <= s3;
      s4_prod  <= prod;
      out_data <= res;
    end
  end

  // offset moved to Q.24, then arithmetic shift gives the floor
  assign acc = {s4_prod[macc_pkg::PROD_W-1], s4_prod}
             + {{(macc_pkg::ACC_W - macc_pkg::COEF_W - macc_pkg::FRAC_DROP)
                 {s4.offset[macc_pkg::COEF_W-1]}},
                s4.offset, macc_pkg::FRAC_DROP'(0)};
  assign q   = acc[macc_pkg::ACC_W-1:macc_pkg::FRAC_DROP];

  always_comb begin
    if (q[macc_pkg::Q_W-1:macc_pkg::COEF_W-1] == '0
        || q[macc_pkg::Q_W-1:macc_pkg::COEF_W-1] == '1) begin
      volt = q[macc_pkg::COEF_W-1:0];
    end else if (q[macc_pkg::Q_W-1]) begin
      volt = macc_pkg::VOLT_MIN;
    end else begin
      volt = macc_pkg::VOLT_MAX;
    end
  end

  always_comb begin
    res.out_channel   = s4.channel;
    res.last_sample   = s4.last_sample;
    res.mean          = s4.mean;
    res.channel_error = s4.err;
    res.voltage       = s4.err ? '0 : volt;
  end

endmodule

`default_nettype wire
